// ----- src/tkv_pkg.sv -----
// Shared types and constants of the key-value record store.
// No dependencies; imported by the top level, front end, back end and testbench.
package tkv_pkg;

	localparam int STORE_BYTES = 1024;
	localparam int STORE_AW    = 10;
	localparam int MAX_KEY     = 16;
	localparam int MAX_VALUE   = 32;

	localparam logic [2:0] KIND_KEY    = 3'd0;
	localparam logic [2:0] KIND_VALUE  = 3'd1;
	localparam logic [2:0] KIND_WRITE  = 3'd2;
	localparam logic [2:0] KIND_READ   = 3'd3;
	localparam logic [2:0] KIND_DELETE = 3'd4;
	localparam logic [2:0] KIND_EXISTS = 3'd5;
	localparam logic [2:0] KIND_FLUSH  = 3'd6;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_SIZE     = 3'd2;
	localparam logic [2:0] ST_NOSPACE  = 3'd3;
	localparam logic [2:0] ST_TOOLONG  = 3'd4;

	typedef enum logic [2:0] {
		OP_KEY, OP_VAL, OP_WRITE, OP_READ, OP_DEL, OP_EXISTS, OP_FLUSH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic [5:0] req;
	} cmd_t;

endpackage

// ----- src/tlv_key_value_store.sv -----
// Top level of the key-value record store: capacity register, front, back.
// Depends on tkv_pkg, tkv_front, tkv_back.
//
//   channel | signals                                   | handshake
//   in      | kind, data_byte, request_length           | in_valid / in_ready
//   out     | status, value_byte, last, dirty, used_bytes | out_valid / out_ready
//   cfg     | cfg_wdata (capacity)                      | cfg_we, no wait
//
// A staging word is taken by the back end while idle. A command walks the records,
// reading each record's key length, value length and compared key bytes, then
// reads or overwrites value bytes, appends a record or moves the bytes behind a
// deleted record. The record RAM has a single read port.
// Reset empties the store at once; a result waiting on out_ready stalls the back
// end once it has another result word, while the two-word queue accepts until full.
module tlv_key_value_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic [5:0]  request_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  value_byte,
	output logic        last,
	output logic        dirty,
	output logic [10:0] used_bytes,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata
);
	import tkv_pkg::*;

	logic        cmd_valid;
	cmd_t        cmd;
	logic        cmd_pop;
	logic [10:0] capacity_q;

	// hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 11'(STORE_BYTES);
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	tkv_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.data_byte      (data_byte),
		.request_length (request_length),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop)
	);

	tkv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.cap        (capacity_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.value_byte (value_byte),
		.last       (last),
		.dirty      (dirty),
		.used_bytes (used_bytes)
	);
endmodule

// ----- src/tkv_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
module tkv_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- src/tkv_front.sv -----
// Front end: accepts input words, classifies the kind, queues commands.
// Depends on tkv_pkg.
module tkv_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    kind,
	input  logic [7:0]    data_byte,
	input  logic [5:0]    request_length,
	output logic          cmd_valid,
	output tkv_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import tkv_pkg::*;

	cmd_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       push;
	logic       keep;
	cmd_t       cls;

	// classify the kind of the incoming word
	always_comb begin
		keep = 1'b1;
		cls.data_byte = data_byte;
		cls.req = request_length;
		case (kind)
			KIND_KEY:    cls.op = OP_KEY;
			KIND_VALUE:  cls.op = OP_VAL;
			KIND_WRITE:  cls.op = OP_WRITE;
			KIND_READ:   cls.op = OP_READ;
			KIND_DELETE: cls.op = OP_DEL;
			KIND_EXISTS: cls.op = OP_EXISTS;
			KIND_FLUSH:  cls.op = OP_FLUSH;
			default: begin
				cls.op = OP_KEY;
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_q];

	// two-entry queue: push at tail, pop at head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				slot_q[rd_q ^ cnt_q[0]] <= cls;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end
endmodule

// ----- src/tkv_back.sv -----
// Back end: staging buffers, record walk sequencer and result register.
// Depends on tkv_pkg and tkv_ram.
module tkv_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  tkv_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic [10:0]   cap,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    status,
	output logic [7:0]    value_byte,
	output logic          last,
	output logic          dirty,
	output logic [10:0]   used_bytes
);
	import tkv_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LK, S_LKW, S_LV, S_CRD, S_CCHK, S_ACT, S_WUPD, S_APP,
		S_RISS, S_REMIT, S_MVRD, S_MVWR, S_FIN
	} state_t;

	state_t      state_q;
	op_t         op_q;
	logic [5:0]  req_q;
	logic [10:0] used_q;
	logic        dirty_q;
	logic [4:0]  kc_q;
	logic [5:0]  vc_q;
	logic        ovf_q;
	logic [7:0]  kst_q [MAX_KEY];
	logic [7:0]  vst_q [MAX_VALUE];
	logic [10:0] pos_q;
	logic [7:0]  klen_q;
	logic [7:0]  vlen_q;
	logic [10:0] vpos_q;
	logic [10:0] nxt_q;
	logic [5:0]  idx_q;
	logic        hit_q;
	logic [2:0]  st_q;
	logic        flush_q;
	logic [10:0] src_q;
	logic [10:0] dst_q;
	logic [10:0] dlen_q;
	logic        ov_q;
	logic [2:0]  ost_q;
	logic [7:0]  ob_q;
	logic        ol_q;
	logic        od_q;
	logic [10:0] ou_q;

	logic [10:0] raddr;
	logic        we;
	logic [10:0] waddr;
	logic [7:0]  wdata;
	logic [7:0]  rdata;
	logic        out_free;
	logic        emit;
	logic [10:0] cap_eff;
	logic [6:0]  need;
	logic [10:0] nxt_c;
	logic [5:0]  kc6;
	logic [7:0]  app_byte;
	logic [5:0]  vi;

	tkv_ram #(.W(8), .DEPTH(STORE_BYTES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr[STORE_AW-1:0]),
		.wdata (wdata),
		.raddr (raddr[STORE_AW-1:0]),
		.rdata (rdata)
	);

	assign out_free = !ov_q || out_ready;
	assign emit     = out_free && ((state_q == S_REMIT) || (state_q == S_FIN));
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign cap_eff  = (cap > 11'(STORE_BYTES)) ? 11'(STORE_BYTES) : cap;
	assign need     = 7'(kc_q) + 7'(vc_q) + 7'd2;
	assign nxt_c    = pos_q + 11'd2 + 11'(klen_q) + 11'(rdata);
	assign kc6      = {1'b0, kc_q};
	assign vi       = idx_q - kc6 - 6'd2;

	// pick the byte of an appended record
	always_comb begin
		if (idx_q == 6'd0) begin
			app_byte = {3'd0, kc_q};
		end else if (idx_q <= kc6) begin
			app_byte = kst_q[4'(idx_q - 6'd1)];
		end else if (idx_q == kc6 + 6'd1) begin
			app_byte = {2'd0, vc_q};
		end else begin
			app_byte = vst_q[vi[4:0]];
		end
	end

	// drive the store ports from the sequencer state
	always_comb begin
		raddr = pos_q;
		we    = 1'b0;
		waddr = used_q + 11'(idx_q);
		wdata = app_byte;
		case (state_q)
			S_LKW:   raddr = pos_q + 11'd1 + 11'(rdata);
			S_CRD:   raddr = pos_q + 11'd1 + 11'(idx_q);
			S_RISS,
			S_REMIT: raddr = vpos_q + 11'd1 + 11'(idx_q);
			S_MVRD:  raddr = src_q;
			S_WUPD: begin
				we    = 1'b1;
				waddr = vpos_q + 11'd1 + 11'(idx_q);
				wdata = vst_q[idx_q[4:0]];
			end
			S_APP:   we = 1'b1;
			S_MVWR: begin
				we    = 1'b1;
				waddr = dst_q;
				wdata = rdata;
			end
			default: raddr = pos_q;
		endcase
	end

	// sequencer, staging and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= 11'd0;
			dirty_q <= 1'b0;
			kc_q    <= 5'd0;
			vc_q    <= 6'd0;
			ovf_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (out_ready && !emit) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd.op;
						req_q   <= cmd.req;
						flush_q <= (cmd.op == OP_FLUSH);
						pos_q   <= 11'd0;
						st_q    <= ST_OK;
						case (cmd.op)
							OP_KEY: begin
								if (kc_q < 5'(MAX_KEY)) begin
									kst_q[kc_q[3:0]] <= cmd.data_byte;
									kc_q <= kc_q + 5'd1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_VAL: begin
								if (vc_q < 6'(MAX_VALUE)) begin
									vst_q[vc_q[4:0]] <= cmd.data_byte;
									vc_q <= vc_q + 6'd1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_FLUSH: state_q <= S_FIN;
							default: begin
								if (ovf_q) begin
									st_q    <= ST_TOOLONG;
									state_q <= S_FIN;
								end else begin
									state_q <= S_LK;
								end
							end
						endcase
					end
				end
				// walk the records: key length, value length, key bytes
				S_LK: begin
					if (pos_q >= used_q) begin
						hit_q   <= 1'b0;
						state_q <= S_ACT;
					end else begin
						state_q <= S_LKW;
					end
				end
				S_LKW: begin
					klen_q  <= rdata;
					vpos_q  <= pos_q + 11'd1 + 11'(rdata);
					state_q <= S_LV;
				end
				S_LV: begin
					vlen_q <= rdata;
					nxt_q  <= nxt_c;
					idx_q  <= 6'd0;
					if (klen_q == {3'd0, kc_q}) begin
						if (kc_q == 5'd0) begin
							hit_q   <= 1'b1;
							state_q <= S_ACT;
						end else begin
							state_q <= S_CRD;
						end
					end else begin
						pos_q   <= nxt_c;
						state_q <= S_LK;
					end
				end
				S_CRD: state_q <= S_CCHK;
				S_CCHK: begin
					if (rdata != kst_q[idx_q[3:0]]) begin
						pos_q   <= nxt_q;
						state_q <= S_LK;
					end else if (idx_q + 6'd1 == kc6) begin
						hit_q   <= 1'b1;
						state_q <= S_ACT;
					end else begin
						idx_q   <= idx_q + 6'd1;
						state_q <= S_CRD;
					end
				end
				// choose the action once the walk has ended
				S_ACT: begin
					idx_q   <= 6'd0;
					state_q <= S_FIN;
					case (op_q)
						OP_WRITE: begin
							if (hit_q) begin
								if (vlen_q != {2'd0, vc_q}) begin
									st_q <= ST_SIZE;
								end else if (vc_q == 6'd0) begin
									dirty_q <= 1'b1;
								end else begin
									state_q <= S_WUPD;
								end
							end else if ({1'b0, used_q} + 12'(need) > {1'b0, cap_eff}) begin
								st_q <= ST_NOSPACE;
							end else begin
								state_q <= S_APP;
							end
						end
						OP_READ: begin
							if (!hit_q) begin
								st_q <= ST_NOTFOUND;
							end else if (vlen_q != {2'd0, req_q}) begin
								st_q <= ST_SIZE;
							end else if (req_q != 6'd0) begin
								state_q <= S_RISS;
							end
						end
						OP_DEL: begin
							if (!hit_q) begin
								st_q <= ST_NOTFOUND;
							end else begin
								src_q  <= nxt_q;
								dst_q  <= pos_q;
								dlen_q <= nxt_q - pos_q;
								if (nxt_q >= used_q) begin
									used_q  <= pos_q;
									dirty_q <= 1'b1;
								end else begin
									state_q <= S_MVRD;
								end
							end
						end
						default: st_q <= hit_q ? ST_OK : ST_NOTFOUND;
					endcase
				end
				// overwrite the value in place
				S_WUPD: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q + 6'd1 == vc_q) begin
						dirty_q <= 1'b1;
						state_q <= S_FIN;
					end
				end
				// append a new record at the end
				S_APP: begin
					idx_q <= idx_q + 6'd1;
					if (7'(idx_q) + 7'd1 == need) begin
						used_q  <= used_q + 11'(need);
						dirty_q <= 1'b1;
						state_q <= S_FIN;
					end
				end
				// stream the value bytes
				S_RISS: state_q <= S_REMIT;
				S_REMIT: begin
					if (out_free) begin
						ov_q  <= 1'b1;
						ost_q <= ST_OK;
						ob_q  <= rdata;
						ol_q  <= (idx_q + 6'd1 == req_q);
						od_q  <= dirty_q;
						ou_q  <= used_q;
						if (idx_q + 6'd1 == req_q) begin
							kc_q    <= 5'd0;
							vc_q    <= 6'd0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 6'd1;
							state_q <= S_RISS;
						end
					end
				end
				// compact the store over the deleted record
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					src_q <= src_q + 11'd1;
					dst_q <= dst_q + 11'd1;
					if (src_q + 11'd1 == used_q) begin
						used_q  <= used_q - dlen_q;
						dirty_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_MVRD;
					end
				end
				// deliver the closing word
				S_FIN: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						ost_q   <= st_q;
						ob_q    <= 8'd0;
						ol_q    <= 1'b1;
						od_q    <= dirty_q;
						ou_q    <= used_q;
						state_q <= S_IDLE;
						if (flush_q) begin
							dirty_q <= 1'b0;
						end else begin
							kc_q  <= 5'd0;
							vc_q  <= 6'd0;
							ovf_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign status     = ost_q;
	assign value_byte = ob_q;
	assign last       = ol_q;
	assign dirty      = od_q;
	assign used_bytes = ou_q;
endmodule

// ----- src/tkv_checker.sv -----
// Port-level checks on the result channel of the record store.
// Depends on tlv_key_value_store (bound to it).
module tkv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  kind,
	input logic [7:0]  data_byte,
	input logic [5:0]  request_length,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [7:0]  value_byte,
	input logic        last,
	input logic        dirty,
	input logic [10:0] used_bytes,
	input logic        cfg_we,
	input logic [10:0] cfg_wdata
);
	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_byte))
		else $error("result word changed under stall");

	// used bytes never exceed the store
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_bytes <= 11'd1024)
		else $error("used bytes beyond store");

	// only streamed read bytes may be non-final, and they are ok
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == 3'd0)
		else $error("non-final word with error status");

	// a value byte comes only with ok status
	a_vbyte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_byte != 8'd0 |-> status == 3'd0)
		else $error("value byte on error word");
endmodule

bind tlv_key_value_store tkv_checker u_tkv_checker (.*);

// ----- dv/tlv_key_value_store_tb.sv -----
// Self-checking testbench for the key-value record store (tlv_key_value_store).
// Depends on tkv_pkg and the RTL; a built-in predictor checks every result word.
module tlv_key_value_store_tb;
	import tkv_pkg::*;

	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 64;
	localparam int POOL = 6;

	typedef struct {
		logic [2:0]  status;
		logic [7:0]  value_byte;
		logic        last;
		logic        dirty;
		logic [10:0] used_bytes;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = KIND_KEY;
	logic [7:0]  data_byte = 8'd0;
	logic [5:0]  request_length = 6'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  value_byte;
	logic        last;
	logic        dirty;
	logic [10:0] used_bytes;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_wdata = 11'd0;

	// predictor state
	logic [7:0]  store_mem [STORE_BYTES];
	int          used_len;
	logic        dirty_mark;
	logic [7:0]  key_buf [MAX_KEY];
	int          key_cnt;
	logic [7:0]  val_buf [MAX_VALUE];
	int          val_cnt;
	logic        overflow;
	int          capacity_q = 1024;

	result_t     expected_q [$];
	int          mismatches;
	int          words_sent;
	int          results_checked;
	int          status_seen [5];
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_left;

	// key pool for random traffic
	logic [7:0]  pool_key [POOL][MAX_KEY];
	int          pool_klen [POOL];
	int          pool_vlen [POOL];

	tlv_key_value_store dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .data_byte(data_byte), .request_length(request_length),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .value_byte(value_byte), .last(last), .dirty(dirty),
		.used_bytes(used_bytes),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// queue one expected result word
	function automatic void push_result(logic [2:0] st, logic [7:0] vb, logic lst);
		result_t r;
		r.status = st;
		r.value_byte = vb;
		r.last = lst;
		r.dirty = dirty_mark;
		r.used_bytes = used_len[10:0];
		expected_q.push_back(r);
	endfunction

	// search the records for the staged key
	function automatic bit find_key(output int rs, output int va, output int re);
		int pos;
		int klen;
		bit same;
		pos = 0;
		rs = 0;
		va = 0;
		re = 0;
		while (pos < used_len) begin
			klen = store_mem[pos];
			same = (klen == key_cnt);
			for (int i = 0; same && i < klen; i++)
				if (store_mem[pos + 1 + i] != key_buf[i])
					same = 0;
			if (same) begin
				rs = pos;
				va = pos + 1 + klen;
				re = va + 1 + store_mem[va];
				return 1;
			end
			pos = pos + 1 + klen;
			pos = pos + 1 + store_mem[pos];
		end
		return 0;
	endfunction

	// work out the result words of one accepted word
	function automatic void store_predict(logic [2:0] k, logic [7:0] b, logic [5:0] r);
		int rs, va, re, cap, p;
		bit hit;
		bit streamed;
		logic [2:0] st;
		st = ST_OK;
		streamed = 0;
		if (k == KIND_KEY) begin
			if (key_cnt < MAX_KEY) key_buf[key_cnt++] = b;
			else overflow = 1;
			return;
		end
		if (k == KIND_VALUE) begin
			if (val_cnt < MAX_VALUE) val_buf[val_cnt++] = b;
			else overflow = 1;
			return;
		end
		if (k == KIND_FLUSH) begin
			push_result(ST_OK, 8'd0, 1'b1);
			dirty_mark = 0;
			return;
		end
		if (k == KIND_UNUSED) return;
		if (overflow) begin
			st = ST_TOOLONG;
		end else begin
			hit = find_key(rs, va, re);
			case (k)
				KIND_WRITE: begin
					if (hit) begin
						if (store_mem[va] != val_cnt) st = ST_SIZE;
						else begin
							for (int i = 0; i < val_cnt; i++) store_mem[va + 1 + i] = val_buf[i];
							dirty_mark = 1;
						end
					end else begin
						cap = capacity_q > STORE_BYTES ? STORE_BYTES : capacity_q;
						if (used_len + key_cnt + val_cnt + 2 > cap) st = ST_NOSPACE;
						else begin
							p = used_len;
							store_mem[p++] = 8'(key_cnt);
							for (int i = 0; i < key_cnt; i++) store_mem[p++] = key_buf[i];
							store_mem[p++] = 8'(val_cnt);
							for (int i = 0; i < val_cnt; i++) store_mem[p++] = val_buf[i];
							used_len = p;
							dirty_mark = 1;
						end
					end
				end
				KIND_READ: begin
					if (!hit) st = ST_NOTFOUND;
					else if (store_mem[va] != r) st = ST_SIZE;
					else if (r > 0) begin
						for (int i = 0; i < r; i++)
							push_result(ST_OK, store_mem[va + 1 + i], i + 1 == r);
						streamed = 1;
					end
				end
				KIND_DELETE: begin
					if (!hit) st = ST_NOTFOUND;
					else begin
						if (re > used_len) re = used_len;
						for (int i = 0; i < used_len - re; i++)
							store_mem[rs + i] = store_mem[re + i];
						used_len -= re - rs;
						dirty_mark = 1;
					end
				end
				default: st = hit ? ST_OK : ST_NOTFOUND;
			endcase
		end
		key_cnt = 0;
		val_cnt = 0;
		overflow = 0;
		if (!streamed) push_result(st, 8'd0, 1'b1);
	endfunction

	// offer one word and hold it until accepted
	task automatic send_word(input logic [2:0] k, input logic [7:0] b, input logic [5:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		request_length <= r;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		store_predict(k, b, r);
		words_sent++;
	endtask

	task automatic stage_key(input int p);
		for (int i = 0; i < pool_klen[p]; i++) send_word(KIND_KEY, pool_key[p][i], 6'd0);
	endtask

	task automatic stage_value(input int n);
		for (int i = 0; i < n; i++) send_word(KIND_VALUE, 8'($urandom_range(255)), 6'd0);
	endtask

	// drop valid, wait for every expected word, then let the back end settle
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input int value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value[10:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_q = value;
	endtask

	task automatic new_pool;
		for (int p = 0; p < POOL; p++) begin
			pool_klen[p] = (p == 0) ? MAX_KEY : $urandom_range(MAX_KEY);
			pool_vlen[p] = ($urandom_range(9) == 0) ? $urandom_range(MAX_VALUE) : $urandom_range(8);
			for (int i = 0; i < MAX_KEY; i++) pool_key[p][i] = 8'($urandom_range(255));
		end
	endtask

	// extremes, every command and every special case
	task automatic test_directed;
		new_pool();
		pool_key[1][0] = 8'hFF;
		pool_klen[1] = 1;
		pool_klen[2] = 0;
		send_word(KIND_FLUSH, 8'h00, 6'd0);
		stage_key(0);
		send_word(KIND_EXISTS, 8'h00, 6'd0);
		stage_key(0);
		stage_value(MAX_VALUE);
		send_word(KIND_WRITE, 8'h00, 6'd0);
		stage_key(0);
		send_word(KIND_READ, 8'h00, 6'd32);
		stage_key(0);
		send_word(KIND_READ, 8'hFF, 6'd63);
		stage_key(0);
		stage_value(MAX_VALUE);
		send_word(KIND_WRITE, 8'h00, 6'd0);
		stage_key(0);
		stage_value(3);
		send_word(KIND_WRITE, 8'h00, 6'd0);
		send_word(KIND_WRITE, 8'h00, 6'd0);
		send_word(KIND_READ, 8'h00, 6'd0);
		stage_key(1);
		send_word(KIND_DELETE, 8'h00, 6'd0);
		for (int i = 0; i <= MAX_KEY; i++) send_word(KIND_KEY, 8'hA5, 6'd0);
		send_word(KIND_WRITE, 8'h00, 6'd0);
		stage_value(MAX_VALUE + 1);
		send_word(KIND_READ, 8'h00, 6'd0);
		send_word(KIND_UNUSED, 8'hFF, 6'h3F);
		stage_key(0);
		send_word(KIND_DELETE, 8'h00, 6'd0);
		send_word(KIND_FLUSH, 8'h00, 6'd0);
		send_word(KIND_FLUSH, 8'h00, 6'd0);
		set_capacity(0);
		stage_key(1);
		send_word(KIND_WRITE, 8'h00, 6'd0);
		set_capacity(1023);
	endtask

	// mostly well-formed commands on a small key pool, some noise
	task automatic test_random(input int n_words);
		int stop_at;
		int p, pick, vlen;
		stop_at = words_sent + n_words;
		new_pool();
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			p = $urandom_range(POOL - 1);
			if (pick < 8) begin
				send_word(3'($urandom_range(7)), 8'($urandom_range(255)),
					6'($urandom_range(63)));
			end else if (pick < 13) begin
				send_word(KIND_FLUSH, 8'h00, 6'd0);
			end else if (pick < 18) begin
				if ($urandom_range(1)) for (int i = 0; i <= MAX_KEY; i++)
					send_word(KIND_KEY, 8'($urandom_range(255)), 6'd0);
				else stage_value(MAX_VALUE + 1);
				send_word(3'($urandom_range(KIND_WRITE, KIND_EXISTS)), 8'h00, 6'd0);
			end else begin
				stage_key(p);
				pick = $urandom_range(99);
				if (pick < 38) begin
					vlen = ($urandom_range(4) == 0) ? $urandom_range(MAX_VALUE) : pool_vlen[p];
					stage_value(vlen);
					send_word(KIND_WRITE, 8'h00, 6'd0);
				end else if (pick < 70) begin
					send_word(KIND_READ, 8'($urandom_range(255)),
						6'(($urandom_range(4) == 0) ? $urandom_range(63) : pool_vlen[p]));
				end else if (pick < 85) begin
					send_word(KIND_DELETE, 8'h00, 6'd0);
				end else begin
					send_word(KIND_EXISTS, 8'h00, 6'd0);
				end
			end
		end
	endtask

	// hold the receiver off while long reads pile up, then let the sender wait
	task automatic test_backpressure;
		new_pool();
		pool_klen[0] = 2;
		pool_vlen[0] = MAX_VALUE;
		stage_key(0);
		stage_value(MAX_VALUE);
		send_word(KIND_WRITE, 8'h00, 6'd0);
		hold_left = 400;
		for (int i = 0; i < 2; i++) begin
			stage_key(0);
			send_word(KIND_READ, 8'h00, 6'd32);
		end
		drain();
		stage_key(0);
		send_word(KIND_DELETE, 8'h00, 6'd0);
	endtask

	// receiver: random stalls plus the long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare each accepted result word with the oldest expectation
	initial begin
		result_t e;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: status %0d byte %0h", status, value_byte);
				end else begin
					e = expected_q.pop_front();
					results_checked++;
					if (e.status < 5) status_seen[e.status]++;
					if (status !== e.status || value_byte !== e.value_byte || last !== e.last ||
							dirty !== e.dirty || used_bytes !== e.used_bytes) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp st %0d vb %0h last %0b dirty %0b used %0d, got st %0d vb %0h last %0b dirty %0b used %0d",
								e.status, e.value_byte, e.last, e.dirty, e.used_bytes,
								status, value_byte, last, dirty, used_bytes);
					end
				end
			end
		end
	end

	// end the run if nothing moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout with %0d words still expected", expected_q.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		used_len = 0;
		dirty_mark = 0;
		key_cnt = 0;
		val_cnt = 0;
		overflow = 0;
		mismatches = 0;
		words_sent = 0;
		results_checked = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		send_idle_pct = 23;
		recv_idle_pct = 79;
		set_capacity(1024);
		test_random(14);
		test_backpressure();
		send_idle_pct = 79;
		recv_idle_pct = 23;
		set_capacity(120);
		test_random(10);
		set_capacity(2047);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(14);

		drain();
		mismatches += expected_q.size();
		$display("%0d words sent, %0d result words checked", words_sent, results_checked);
		$display("status counts ok %0d notfound %0d size %0d nospace %0d toolong %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/tkv_pkg.sv
src/tkv_ram.sv
src/tkv_front.sv
src/tkv_back.sv
src/tlv_key_value_store.sv
src/tkv_checker.sv
dv/tlv_key_value_store_tb.sv
